@@ src/fat12_cluster_chain_walker_assert.svh @@
// Assertion macros used by the chain walker's checker.
`ifndef FAT12_CLUSTER_CHAIN_WALKER_ASSERT_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FCCW_CHK_SAME(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fccw: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define FCCW_CHK_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fccw: next-cycle check failed");

`endif

@@ src/fccw_pkg.sv @@
// Types and constants shared by the FAT12 cluster chain walker.
`default_nettype none
package fccw_pkg;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_OPEN = 2'd1;
    localparam logic [1:0] OP_NEXT = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_NO_CHAIN = 2'd2;
    localparam logic [1:0] ST_BAD_CL   = 2'd3;

    localparam logic [2:0] REG_BPS    = 3'd0;
    localparam logic [2:0] REG_SPC    = 3'd1;
    localparam logic [2:0] REG_RSV    = 3'd2;
    localparam logic [2:0] REG_COPIES = 3'd3;
    localparam logic [2:0] REG_SPF    = 3'd4;
    localparam logic [2:0] REG_REC    = 3'd5;

    localparam logic [11:0] CHAIN_END    = 12'hFF8;
    localparam logic [7:0]  NAME_FREE    = 8'h00;
    localparam logic [7:0]  NAME_SPACE   = 8'h20;
    localparam logic [7:0]  NAME_DELETED = 8'hE5;
    localparam logic [7:0]  NAME_KANJI   = 8'h05;
    localparam logic [7:0]  ATTR_VOLUME  = 8'h08;
    localparam logic [19:0] LEN_MAX      = 20'hFFFFF;

    localparam logic [5:0] STEPS_8   = 6'd8;
    localparam logic [5:0] STEPS_12  = 6'd12;
    localparam logic [5:0] STEPS_13  = 6'd13;
    localparam logic [5:0] STEPS_16  = 6'd16;
    localparam logic [5:0] STEPS_SH5 = 6'd6;
    localparam logic [5:0] STEPS_32  = 6'd32;

    typedef logic [2:0]  t_cfg_idx;
    typedef logic [15:0] t_cfg_data;

    typedef struct packed {
        logic [1:0]  operation;
        logic [12:0] fat_index;
        logic [7:0]  fat_byte;
        logic [7:0]  name_first_byte;
        logic [7:0]  attributes;
        logic [11:0] start_cluster;
        logic [31:0] size_bytes;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data_offset;
        logic [19:0] data_length;
        logic [11:0] cluster;
        logic        last;
    } t_res;

    typedef struct packed {
        logic        load;
        logic        mode_mod;
        logic [31:0] acc_init;
        logic [31:0] opa;
        logic [31:0] opb;
        logic [5:0]  steps;
    } t_alu_cmd;

    typedef struct packed {
        logic        busy;
        logic [31:0] acc;
    } t_alu_sts;

    function automatic logic [19:0] sat_len(input logic [20:0] v);
        return v[20] ? LEN_MAX : v[19:0];
    endfunction

endpackage
`default_nettype wire

@@ src/fccw_fat_ram.sv @@
// FAT byte store: one write port and one registered read port.
`default_nettype none
module fccw_fat_ram #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [7:0]        o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ src/fccw_alu.sv @@
// Shared serial unit: shift-add multiply-accumulate and restoring remainder.
`default_nettype none
module fccw_alu (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fccw_pkg::t_alu_cmd i_cmd,
    output fccw_pkg::t_alu_sts      o_sts
);
    import fccw_pkg::*;

    logic [31:0] r_acc;
    logic [31:0] r_opa;
    logic [31:0] r_opb;
    logic        r_mod;
    logic [5:0]  r_cnt;

    logic [31:0] lhs;
    logic [31:0] addend;
    logic [32:0] sum;
    logic        busy;

    assign lhs    = r_mod ? {r_acc[30:0], r_opa[31]} : r_acc;
    assign addend = r_mod ? ~r_opb : r_opa;
    assign sum    = {1'b0, lhs} + {1'b0, addend} + {32'd0, r_mod};
    assign busy   = (r_cnt != 6'd0) && (r_mod || (r_opb != 32'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
            r_mod <= 1'b0;
        end else if (i_cmd.load) begin
            r_acc <= i_cmd.acc_init;
            r_opa <= i_cmd.opa;
            r_opb <= i_cmd.opb;
            r_mod <= i_cmd.mode_mod;
            r_cnt <= i_cmd.steps;
        end else if (busy) begin
            r_cnt <= r_cnt - 6'd1;
            r_opa <= {r_opa[30:0], 1'b0};
            if (r_mod) begin
                r_acc <= sum[32] ? sum[31:0] : lhs;
            end else begin
                if (r_opb[0]) begin
                    r_acc <= sum[31:0];
                end
                r_opb <= {1'b0, r_opb[31:1]};
            end
        end
    end

    assign o_sts.busy = busy;
    assign o_sts.acc  = r_acc;
endmodule
`default_nettype wire

@@ src/fat12_cluster_chain_walker.sv @@
// Top level of the FAT12 cluster chain walker: sequencer, registers and FAT store.
//
// Requests are issued on start with the payload on i_req and are taken when
// busy is low. Every request gives exactly one result, shown on o_res for one
// cycle with o_strobe high; the receiver cannot stall it.
// Loads, opens, next requests with no open chain and next requests on a
// cluster below two give their result in the cycle after the request, and
// the block is ready again at once.
// A next request on an open chain runs on the serial multiply/remainder
// unit: it adds (cluster - 2), at most 12 bits wide, times the cluster size
// to the data area start for the data offset, fetches the FAT entry through
// the store's single read port in S_F0, S_F1 and S_F2, and at the end of
// the chain takes the remainder of the file size when the cluster size is not zero.
// After reset or any register write the volume geometry is recomputed once,
// in S_CS and S_R1 to S_R4, on the next such request. A link gives its result
// from S_F2 and the last cluster, if the cluster size is not zero, from S_MOD;
// the next request can be taken in the cycle that shows the result.
// Registers are written on the cfg channel, which is ready only while the
// block is idle and start is low. Reset loads the register defaults, closes
// any chain and leaves the FAT store contents as they were.
`default_nettype none
module fat12_cluster_chain_walker #(
    parameter int FAT_BYTES = 8192
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire fccw_pkg::t_req      i_req,
    output logic                     busy,
    output logic                     o_strobe,
    output fccw_pkg::t_res           o_res,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire fccw_pkg::t_cfg_idx  i_cfg_index,
    input  wire fccw_pkg::t_cfg_data i_cfg_data
);
    import fccw_pkg::*;

    localparam int ADDR_W = $clog2(FAT_BYTES);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CS   = 4'd1;
    localparam logic [3:0] S_R1   = 4'd2;
    localparam logic [3:0] S_R2   = 4'd3;
    localparam logic [3:0] S_R3   = 4'd4;
    localparam logic [3:0] S_R4   = 4'd5;
    localparam logic [3:0] S_OFF  = 4'd6;
    localparam logic [3:0] S_F0   = 4'd7;
    localparam logic [3:0] S_F1   = 4'd8;
    localparam logic [3:0] S_F2   = 4'd9;
    localparam logic [3:0] S_MOD  = 4'd10;

    logic [3:0]  r_state;
    logic [3:0]  n_state;
    logic [12:0] r_bps;
    logic [12:0] n_bps;
    logic [7:0]  r_spc;
    logic [7:0]  n_spc;
    logic [15:0] r_rsv;
    logic [15:0] n_rsv;
    logic [7:0]  r_copies;
    logic [7:0]  n_copies;
    logic [15:0] r_spf;
    logic [15:0] n_spf;
    logic [15:0] r_rec;
    logic [15:0] n_rec;
    logic        r_geom_ok;
    logic        n_geom_ok;
    logic [20:0] r_csize;
    logic [20:0] n_csize;
    logic [31:0] r_root;
    logic [31:0] n_root;
    logic [31:0] r_off;
    logic [31:0] n_off;
    logic [11:0] r_cur;
    logic [11:0] n_cur;
    logic        r_active;
    logic        n_active;
    logic [31:0] r_size;
    logic [31:0] n_size;
    logic [7:0]  r_lo;
    logic [7:0]  n_lo;
    logic        r_strobe;
    logic        n_strobe;
    t_res        r_res;
    t_res        n_res;

    t_alu_cmd          alu_cmd;
    t_alu_sts          alu_sts;
    logic              alu_done;
    logic              accept;
    logic              cfg_we;
    logic              entry_ok;
    logic              chain_go;
    logic [12:0]       pos;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        rdata;
    logic              ram_we;
    logic [11:0]       nx;
    logic [31:0]       cl_rel;
    logic [19:0]       rem_len;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = !busy && !start;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign alu_done    = !alu_sts.busy;
    assign o_strobe    = r_strobe;
    assign o_res       = r_res;

    assign entry_ok = (i_req.start_cluster != 12'd0) &&
                      (i_req.name_first_byte != NAME_FREE) &&
                      (i_req.name_first_byte != NAME_SPACE) &&
                      (i_req.name_first_byte != NAME_DELETED) &&
                      (i_req.name_first_byte != NAME_KANJI) &&
                      ((i_req.attributes & ATTR_VOLUME) == 8'd0);
    assign chain_go = accept && (i_req.operation == OP_NEXT) && r_active &&
                      (r_cur >= 12'd2);

    assign pos    = {1'b0, r_cur} + {2'b00, r_cur[11:1]};
    assign cl_rel = {20'd0, r_cur - 12'd2};
    assign nx     = r_cur[0] ? {rdata, r_lo[7:4]} : {rdata[3:0], r_lo};
    assign rem_len = (alu_sts.acc[20:0] != 21'd0) ? sat_len(alu_sts.acc[20:0])
                                                  : sat_len(r_csize);
    assign ram_we = accept && (i_req.operation == OP_LOAD) &&
                    (int'(i_req.fat_index) < FAT_BYTES);
    assign raddr  = (r_state == S_F1) ? ADDR_W'(pos + 13'd1) : ADDR_W'(pos);

    fccw_fat_ram #(
        .DEPTH  (FAT_BYTES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(i_req.fat_index)),
        .i_wdata (i_req.fat_byte),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    fccw_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (alu_cmd),
        .o_sts   (alu_sts)
    );

    always_comb begin
        n_state = r_state;
        alu_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (chain_go) begin
                    alu_cmd.load = 1'b1;
                    if (!r_geom_ok) begin
                        alu_cmd.opa   = {19'd0, r_bps};
                        alu_cmd.opb   = {24'd0, r_spc};
                        alu_cmd.steps = STEPS_8;
                        n_state       = S_CS;
                    end else begin
                        alu_cmd.acc_init = r_root;
                        alu_cmd.opa      = {11'd0, r_csize};
                        alu_cmd.opb      = cl_rel;
                        alu_cmd.steps    = STEPS_12;
                        n_state          = S_OFF;
                    end
                end
            end
            S_CS: begin
                if (alu_done) begin
                    alu_cmd.load  = 1'b1;
                    alu_cmd.opa   = {19'd0, r_bps};
                    alu_cmd.opb   = {16'd0, r_rsv};
                    alu_cmd.steps = STEPS_16;
                    n_state       = S_R1;
                end
            end
            S_R1: begin
                if (alu_done) begin
                    alu_cmd.load  = 1'b1;
                    alu_cmd.opa   = {16'd0, r_spf};
                    alu_cmd.opb   = {24'd0, r_copies};
                    alu_cmd.steps = STEPS_8;
                    n_state       = S_R2;
                end
            end
            S_R2: begin
                if (alu_done) begin
                    alu_cmd.load     = 1'b1;
                    alu_cmd.acc_init = r_root;
                    alu_cmd.opa      = alu_sts.acc;
                    alu_cmd.opb      = {19'd0, r_bps};
                    alu_cmd.steps    = STEPS_13;
                    n_state          = S_R3;
                end
            end
            S_R3: begin
                if (alu_done) begin
                    alu_cmd.load     = 1'b1;
                    alu_cmd.acc_init = alu_sts.acc;
                    alu_cmd.opa      = {16'd0, r_rec};
                    alu_cmd.opb      = 32'd32;
                    alu_cmd.steps    = STEPS_SH5;
                    n_state          = S_R4;
                end
            end
            S_R4: begin
                if (alu_done) begin
                    alu_cmd.load     = 1'b1;
                    alu_cmd.acc_init = alu_sts.acc;
                    alu_cmd.opa      = {11'd0, r_csize};
                    alu_cmd.opb      = cl_rel;
                    alu_cmd.steps    = STEPS_12;
                    n_state          = S_OFF;
                end
            end
            S_OFF: begin
                if (alu_done) begin
                    n_state = S_F0;
                end
            end
            S_F0: n_state = S_F1;
            S_F1: n_state = S_F2;
            S_F2: begin
                if ((nx >= CHAIN_END) && (r_csize != 21'd0)) begin
                    alu_cmd.load     = 1'b1;
                    alu_cmd.mode_mod = 1'b1;
                    alu_cmd.opa      = r_size;
                    alu_cmd.opb      = {11'd0, r_csize};
                    alu_cmd.steps    = STEPS_32;
                    n_state          = S_MOD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MOD: begin
                if (alu_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_bps     = r_bps;
        n_spc     = r_spc;
        n_rsv     = r_rsv;
        n_copies  = r_copies;
        n_spf     = r_spf;
        n_rec     = r_rec;
        n_geom_ok = r_geom_ok;
        n_csize   = r_csize;
        n_root    = r_root;
        n_off     = r_off;
        n_cur     = r_cur;
        n_active  = r_active;
        n_size    = r_size;
        n_lo      = r_lo;
        n_strobe  = 1'b0;
        n_res     = r_res;
        if (cfg_we) begin
            n_geom_ok = 1'b0;
            case (i_cfg_index)
                REG_BPS:    n_bps    = i_cfg_data[12:0];
                REG_SPC:    n_spc    = i_cfg_data[7:0];
                REG_RSV:    n_rsv    = i_cfg_data;
                REG_COPIES: n_copies = i_cfg_data[7:0];
                REG_SPF:    n_spf    = i_cfg_data;
                REG_REC:    n_rec    = i_cfg_data;
                default:    n_geom_ok = 1'b0;
            endcase
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_strobe = 1'b1;
                    n_res    = '0;
                    case (i_req.operation)
                        OP_OPEN: begin
                            n_active      = 1'b0;
                            n_res.cluster = i_req.start_cluster;
                            if (!entry_ok) begin
                                n_res.status = ST_INVALID;
                            end else begin
                                n_size     = i_req.size_bytes;
                                n_cur      = i_req.start_cluster;
                                n_active   = (i_req.start_cluster < CHAIN_END);
                                n_res.last = (i_req.start_cluster >= CHAIN_END);
                            end
                        end
                        OP_NEXT: begin
                            if (!r_active) begin
                                n_res.status = ST_NO_CHAIN;
                            end else if (r_cur < 12'd2) begin
                                n_active      = 1'b0;
                                n_res.status  = ST_BAD_CL;
                                n_res.cluster = r_cur;
                            end else begin
                                n_strobe = 1'b0;
                            end
                        end
                        default: n_res = '0;
                    endcase
                end
            end
            S_CS: begin
                if (alu_done) begin
                    n_csize = alu_sts.acc[20:0];
                end
            end
            S_R1: begin
                if (alu_done) begin
                    n_root = alu_sts.acc;
                end
            end
            S_R4: begin
                if (alu_done) begin
                    n_geom_ok = 1'b1;
                    n_root    = alu_sts.acc;
                end
            end
            S_OFF: begin
                if (alu_done) begin
                    n_off = alu_sts.acc;
                end
            end
            S_F1: n_lo = rdata;
            S_F2: begin
                if (nx >= CHAIN_END) begin
                    n_active = 1'b0;
                end else begin
                    n_cur = nx;
                end
                if (!((nx >= CHAIN_END) && (r_csize != 21'd0))) begin
                    n_strobe          = 1'b1;
                    n_res.status      = ST_OK;
                    n_res.data_offset = r_off;
                    n_res.data_length = sat_len(r_csize);
                    n_res.cluster     = r_cur;
                    n_res.last        = (nx >= CHAIN_END);
                end
            end
            S_MOD: begin
                if (alu_done) begin
                    n_strobe          = 1'b1;
                    n_res.status      = ST_OK;
                    n_res.data_offset = r_off;
                    n_res.data_length = rem_len;
                    n_res.cluster     = r_cur;
                    n_res.last        = 1'b1;
                end
            end
            default: n_strobe = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bps     <= 13'd512;
            r_spc     <= 8'd1;
            r_rsv     <= 16'd1;
            r_copies  <= 8'd2;
            r_spf     <= 16'd9;
            r_rec     <= 16'd224;
            r_geom_ok <= 1'b0;
            r_cur     <= 12'd0;
            r_active  <= 1'b0;
            r_size    <= 32'd0;
            r_strobe  <= 1'b0;
        end else begin
            r_bps     <= n_bps;
            r_spc     <= n_spc;
            r_rsv     <= n_rsv;
            r_copies  <= n_copies;
            r_spf     <= n_spf;
            r_rec     <= n_rec;
            r_geom_ok <= n_geom_ok;
            r_cur     <= n_cur;
            r_active  <= n_active;
            r_size    <= n_size;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_csize <= n_csize;
        r_root  <= n_root;
        r_off   <= n_off;
        r_lo    <= n_lo;
        r_res   <= n_res;
    end
endmodule
`default_nettype wire

@@ src/fccw_checker.sv @@
// Port-level checks on the chain walker, bound to its top level.
`default_nettype none
`include "fat12_cluster_chain_walker_assert.svh"
module fccw_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire fccw_pkg::t_req      i_req,
    input wire logic                busy,
    input wire logic                o_strobe,
    input wire fccw_pkg::t_res      o_res,
    input wire logic                o_cfg_ready
);
    import fccw_pkg::*;

    logic quick_req;
    logic next_req;
    logic no_chain_res;

    assign quick_req    = start && !busy && (i_req.operation != OP_NEXT);
    assign next_req     = start && !busy && (i_req.operation == OP_NEXT);
    assign no_chain_res = o_strobe && (o_res.status == ST_NO_CHAIN);

    `FCCW_CHK_NEXT(a_quick_result, quick_req, o_strobe && !busy)
    `FCCW_CHK_NEXT(a_next_progress, next_req, busy || o_strobe)
    `FCCW_CHK_SAME(a_cfg_idle, busy, !o_cfg_ready)
    `FCCW_CHK_SAME(a_last_ok, o_strobe && o_res.last, o_res.status == ST_OK)
    `FCCW_CHK_SAME(a_no_chain_zero, no_chain_res,
                   (o_res.data_offset == 32'd0) && (o_res.cluster == 12'd0))
endmodule

bind fat12_cluster_chain_walker fccw_checker u_fccw_checker (.*);
`default_nettype wire
